>>> rtl/rpnp_pkg.sv
// shared types and character constants for the radix-prefixed number parser
`timescale 1ns / 1ps
`default_nettype none

package rpnp_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 8;
  localparam int unsigned DigitW = 5;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // ascii codes
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch1     = 8'h31;
  localparam logic [7:0] Ch7     = 8'h37;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowB  = 8'h62;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpB   = 8'h42;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChUpX   = 8'h58;

  typedef enum logic [6:0] {
    PhIdle      = 7'b0000001,
    PhAfterSign = 7'b0000010,
    PhAfterZero = 7'b0000100,
    PhHex       = 7'b0001000,
    PhBin       = 7'b0010000,
    PhOct       = 7'b0100000,
    PhDec       = 7'b1000000
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic                neg;
    logic [ValueW-1:0]   acc;
    logic [CountW-1:0]   count;
    logic                seen;
  } parse_state_t;

  typedef struct packed {
    logic                valid;
    logic                ok;
    logic [ValueW-1:0]   value;
    logic [CountW-1:0]   consumed;
  } parse_result_t;

endpackage

`default_nettype wire

>>> rtl/rpnp_step.sv
// next-state and result logic for one character of the parser
`timescale 1ns / 1ps
`default_nettype none

module rpnp_step (
  input  rpnp_pkg::parse_state_t  state_i,
  input  logic [7:0]              char_i,
  input  logic                    start_i,
  output rpnp_pkg::parse_state_t  next_o,
  output rpnp_pkg::parse_result_t result_o
);

  typedef enum logic [3:0] {
    RadixBin = 4'b0001,
    RadixOct = 4'b0010,
    RadixDec = 4'b0100,
    RadixHex = 4'b1000
  } radix_e;

  // acc * radix + digit, radix multiply as shift or shift-add
  function automatic logic [rpnp_pkg::ValueW-1:0] scale_add(
    input logic [rpnp_pkg::ValueW-1:0] acc,
    input radix_e                      radix,
    input logic [rpnp_pkg::DigitW-1:0] dig
  );
    logic [rpnp_pkg::ValueW-1:0] prod;
    begin
      case (radix)
        RadixBin: prod = acc << 1;
        RadixOct: prod = acc << 3;
        RadixDec: prod = (acc << 3) + (acc << 1);
        RadixHex: prod = acc << 4;
        default:  prod = '0;
      endcase
      scale_add = prod + {{(rpnp_pkg::ValueW-rpnp_pkg::DigitW){1'b0}}, dig};
    end
  endfunction

  function automatic logic [rpnp_pkg::CountW-1:0] bump(input logic [rpnp_pkg::CountW-1:0] cnt);
    begin
      bump = (cnt == rpnp_pkg::CountMax) ? cnt : cnt + 1'b1;
    end
  endfunction

  rpnp_pkg::parse_state_t      cur;
  logic [rpnp_pkg::DigitW-1:0] dig;
  logic                        dig_ok;
  logic [rpnp_pkg::DigitW-1:0] dig_lim;
  radix_e                      radix;
  logic                        is_sign;

  // digit decode against the radix of the current phase
  always_comb begin
    dig = '0;
    if (char_i inside {[rpnp_pkg::Ch0:rpnp_pkg::Ch9]}) begin
      dig = rpnp_pkg::DigitW'(char_i - rpnp_pkg::Ch0);
    end else if (char_i inside {[rpnp_pkg::ChLowA:rpnp_pkg::ChLowF]}) begin
      dig = rpnp_pkg::DigitW'(char_i - rpnp_pkg::ChLowA) + rpnp_pkg::DigitW'(10);
    end else if (char_i inside {[rpnp_pkg::ChUpA:rpnp_pkg::ChUpF]}) begin
      dig = rpnp_pkg::DigitW'(char_i - rpnp_pkg::ChUpA) + rpnp_pkg::DigitW'(10);
    end else begin
      dig = 5'd31;
    end
  end

  always_comb begin
    case (state_i.phase)
      rpnp_pkg::PhHex: radix = RadixHex;
      rpnp_pkg::PhBin: radix = RadixBin;
      rpnp_pkg::PhOct: radix = RadixOct;
      default:         radix = RadixDec;
    endcase
    case (radix)
      RadixHex: dig_lim = 5'd16;
      RadixBin: dig_lim = 5'd2;
      RadixOct: dig_lim = 5'd8;
      default:  dig_lim = 5'd10;
    endcase
    dig_ok = (dig < dig_lim);
  end

  assign is_sign = (char_i == rpnp_pkg::ChMinus) || (char_i == rpnp_pkg::ChPlus);

  always_comb begin
    cur = state_i;
    if (start_i) begin
      cur.phase = rpnp_pkg::PhAfterSign;
      cur.neg   = 1'b0;
      cur.acc   = '0;
      cur.count = '0;
      cur.seen  = 1'b0;
    end
    next_o   = cur;
    result_o = '0;

    if (start_i && is_sign) begin
      next_o.neg   = (char_i == rpnp_pkg::ChMinus);
      next_o.count = bump(cur.count);
    end else begin
      case (cur.phase)
        rpnp_pkg::PhAfterSign: begin
          if (char_i == rpnp_pkg::Ch0) begin
            next_o.count = bump(cur.count);
            next_o.phase = rpnp_pkg::PhAfterZero;
          end else if (char_i inside {[rpnp_pkg::Ch1:rpnp_pkg::Ch9]}) begin
            next_o.acc   = scale_add(cur.acc, RadixDec, dig);
            next_o.seen  = 1'b1;
            next_o.count = bump(cur.count);
            next_o.phase = rpnp_pkg::PhDec;
          end else begin
            // no digit after the optional sign
            next_o.phase    = rpnp_pkg::PhIdle;
            result_o.valid  = 1'b1;
          end
        end
        rpnp_pkg::PhAfterZero: begin
          if ((char_i == rpnp_pkg::ChLowX) || (char_i == rpnp_pkg::ChUpX)) begin
            next_o.count = bump(cur.count);
            next_o.phase = rpnp_pkg::PhHex;
          end else if ((char_i == rpnp_pkg::ChLowB) || (char_i == rpnp_pkg::ChUpB)) begin
            next_o.count = bump(cur.count);
            next_o.phase = rpnp_pkg::PhBin;
          end else if (char_i inside {[rpnp_pkg::Ch0:rpnp_pkg::Ch7]}) begin
            next_o.acc   = scale_add(cur.acc, RadixOct, dig);
            next_o.seen  = 1'b1;
            next_o.count = bump(cur.count);
            next_o.phase = rpnp_pkg::PhOct;
          end else begin
            // lone zero, value is zero whatever the sign
            next_o.acc        = '0;
            next_o.phase      = rpnp_pkg::PhIdle;
            result_o.valid    = 1'b1;
            result_o.ok       = 1'b1;
            result_o.consumed = cur.count;
          end
        end
        rpnp_pkg::PhHex, rpnp_pkg::PhBin, rpnp_pkg::PhOct, rpnp_pkg::PhDec: begin
          if (dig_ok) begin
            next_o.acc   = scale_add(cur.acc, radix, dig);
            next_o.seen  = 1'b1;
            next_o.count = bump(cur.count);
          end else begin
            next_o.phase   = rpnp_pkg::PhIdle;
            result_o.valid = 1'b1;
            result_o.ok    = cur.seen;
            if (cur.seen) begin
              result_o.value    = cur.neg ? (~cur.acc + 1'b1) : cur.acc;
              result_o.consumed = cur.count;
            end
          end
        end
        default: begin
          // idle: characters ignored until the next start
          next_o.phase = rpnp_pkg::PhIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/radix_prefixed_number_parser_top.sv
// top level of the radix-prefixed ascii integer parser
// usage:
//   the slave stream carries one ascii character per request in s_axis_tdata
//   and a start-of-string flag in s_axis_tuser; a start drops any parse in
//   progress. a string is an optional sign, then 0x/0X hex, 0b/0B binary,
//   a leading 0 for octal, or decimal digits.
//   the first character that is not a valid digit ends the parse and yields
//   one request on the master stream: m_axis_tuser is the ok flag,
//   m_axis_tdata holds the 32-bit value and the consumed count (saturating
//   at 255). characters after that are dropped until the next start.
// timing:
//   one character per cycle, back to back while s_axis_tready is high; the
//   parse state register is updated by one pass of short logic per character.
//   the result is written to the output register at the edge that takes the
//   ending character and is offered on the master stream in the next cycle.
// reset:
//   the parser returns to idle (waiting for a start), the output is empty.
// stall:
//   while a result waits in the output register and m_axis_tready is low,
//   s_axis_tready drops; otherwise a character is taken every cycle even with
//   a result pending, as long as the receiver takes it in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module radix_prefixed_number_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] first_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] value, [39:32] consumed
  output logic        m_axis_tuser    // [0] ok
);

  rpnp_pkg::parse_state_t  state_q, state_d;
  rpnp_pkg::parse_result_t result;

  logic                          out_valid_q, out_valid_d;
  logic                          out_ok_q;
  logic [rpnp_pkg::ValueW-1:0]   out_value_q;
  logic [rpnp_pkg::CountW-1:0]   out_count_q;
  logic                          in_fire;

  // take a character unless a result is stuck in the output register
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  rpnp_step u_step (
    .state_i  (state_q),
    .char_i   (s_axis_tdata),
    .start_i  (s_axis_tuser),
    .next_o   (state_d),
    .result_o (result)
  );

  // parse state, held when no character arrives
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase <= rpnp_pkg::PhIdle;
      state_q.neg   <= 1'b0;
      state_q.acc   <= '0;
      state_q.count <= '0;
      state_q.seen  <= 1'b0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // output register valid: loaded by a finishing character, cleared when taken
  assign out_valid_d = (in_fire && result.valid) || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire && result.valid) begin
      out_ok_q    <= result.ok;
      out_value_q <= result.value;
      out_count_q <= result.consumed;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = {out_count_q, out_value_q};

endmodule

`default_nettype wire
